[hdl/b2d_pkg.sv]
package b2d_pkg;

	// Default of the digit store depth
	localparam int MAX_CHARS_DEF = 20;

	localparam int VALUE_W      = 64;
	localparam int BUF_LEN_W    = 6;
	localparam int CHAR_W       = 8;
	localparam int TEXT_LEN_W   = 5;
	localparam int DIGIT_W      = 4;
	localparam int BITS_PER_CYC = 4;
	localparam int STEP_CNT_W   = 5;

	// Conversion steps for each operand width at four bits a cycle
	localparam logic [STEP_CNT_W-1:0] WIDE_STEPS   = 5'd16;
	localparam logic [STEP_CNT_W-1:0] NARROW_STEPS = 5'd8;

	localparam logic [CHAR_W-1:0] ASCII_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_OVERFLOW = 1'b1;

	typedef struct packed {
		logic [VALUE_W-1:0]   value;
		logic                 is_signed;
		logic                 is_wide;
		logic [BUF_LEN_W-1:0] buffer_len;
	} in_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0]     char_code;
		logic                  is_last;
		logic                  status;
		logic [TEXT_LEN_W-1:0] text_length;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_CHECK,
		ST_EMIT
	} b2d_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic check;
		logic push;
	} b2d_cmd_t;

	typedef struct packed {
		logic conv_done;
		logic slot_free;
		logic last_char;
	} b2d_stat_t;

endpackage

[hdl/b2d_if.sv]
interface b2d_in_if;
	logic               valid;
	logic               ready;
	b2d_pkg::in_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface b2d_out_if;
	logic               valid;
	logic               ready;
	b2d_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[hdl/binary_to_decimal_ascii_unit.sv]
// Binary to decimal text converter. Each input transaction carries a 32- or
// 64-bit integer, read as two's complement or unsigned, and a buffer limit;
// the unit returns its decimal ASCII text one character per output
// transaction, most significant first, with a leading '-' for negative values
// and a single '0' for zero. The last character carries is_last and the total
// text length. Text longer than buffer_len or than MAX_CHARS yields one
// overflow transaction (NUL character, status 1, length 0) instead. Steps:
// the operand is taken, the shift-and-add-3 converter consumes four bits a
// cycle, the text is sized, then one character leaves per cycle while the
// output is taken. One conversion runs at a time; the next operand is taken
// as soon as the last character sits in the output register.
module binary_to_decimal_ascii_unit #(
	parameter int MAX_CHARS = b2d_pkg::MAX_CHARS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	b2d_in_if.sink    din,
	b2d_out_if.source dout
);
	import b2d_pkg::*;

	b2d_cmd_t  cmd;
	b2d_stat_t stat;
	logic      in_ready;

	// Sequencer: load, convert, size, emit
	b2d_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	assign din.ready = in_ready;

	// Magnitude shifter, BCD digits and output register
	b2d_dpath #(
		.MAX_CHARS (MAX_CHARS)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_item (din.data),
		.cmd     (cmd),
		.stat    (stat),
		.dout    (dout)
	);

endmodule

[hdl/b2d_ctrl.sv]
module b2d_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  b2d_pkg::b2d_stat_t  stat,
	output b2d_pkg::b2d_cmd_t   cmd
);
	import b2d_pkg::*;

	b2d_state_t state_q;
	b2d_state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_n = ST_CONV;
			end
			ST_CONV: begin
				if (stat.conv_done) state_n = ST_CHECK;
			end
			ST_CHECK: begin
				state_n = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.slot_free && stat.last_char) state_n = ST_IDLE;
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_CONV: begin
				cmd.step = 1'b1;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
			end
			ST_EMIT: begin
				cmd.push = stat.slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[hdl/b2d_dpath.sv]
module b2d_dpath #(
	parameter int MAX_CHARS = b2d_pkg::MAX_CHARS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  b2d_pkg::in_item_t  in_item,
	input  b2d_pkg::b2d_cmd_t  cmd,
	output b2d_pkg::b2d_stat_t stat,
	b2d_out_if.source          dout
);
	import b2d_pkg::*;

	localparam int BcdW  = MAX_CHARS * DIGIT_W;
	localparam int PtrW  = $clog2(MAX_CHARS);
	localparam int NdigW = $clog2(MAX_CHARS + 1);
	localparam logic [TEXT_LEN_W-1:0] MaxLen = TEXT_LEN_W'(MAX_CHARS);

	logic [VALUE_W-1:0]    shreg_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic                  neg_q;
	logic [BUF_LEN_W-1:0]  blen_q;
	logic [BcdW-1:0]       bcd_q;
	logic                  bovf_q;
	logic [TEXT_LEN_W-1:0] len_q;
	logic                  ovf_q;
	logic [PtrW-1:0]       ptr_q;
	logic                  sign_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic [31:0]           mag32;
	logic                  neg_n;
	logic [VALUE_W-1:0]    shreg_n;
	logic [BcdW-1:0]       bcd_n;
	logic                  bovf_n;
	logic [NdigW-1:0]      ndig;
	logic [TEXT_LEN_W-1:0] len_n;
	logic                  ovf_n;
	logic [DIGIT_W-1:0]    cur_digit;
	out_item_t             item_n;

	// Sign and magnitude of the operand
	always_comb begin
		mag32 = in_item.value[31:0];
		if (in_item.is_wide) begin
			neg_n   = in_item.is_signed & in_item.value[VALUE_W-1];
			shreg_n = neg_n ? (VALUE_W'(0) - in_item.value) : in_item.value;
		end else begin
			neg_n   = in_item.is_signed & mag32[31];
			shreg_n = {(neg_n ? (32'd0 - mag32) : mag32), 32'd0};
		end
	end

	// Four shift-and-add-3 steps on the BCD digits
	always_comb begin
		bcd_n  = bcd_q;
		bovf_n = bovf_q;
		for (int s = 0; s < BITS_PER_CYC; s++) begin
			for (int d = 0; d < MAX_CHARS; d++) begin
				if (bcd_n[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
					bcd_n[d*DIGIT_W +: DIGIT_W] = bcd_n[d*DIGIT_W +: DIGIT_W] + 4'd3;
				end
			end
			bovf_n = bovf_n | bcd_n[BcdW-1];
			bcd_n  = {bcd_n[BcdW-2:0], shreg_q[VALUE_W-1-s]};
		end
	end

	// Digit count: highest non-zero digit, at least one
	always_comb begin
		ndig = NdigW'(1);
		for (int d = 1; d < MAX_CHARS; d++) begin
			if (bcd_q[d*DIGIT_W +: DIGIT_W] != '0) ndig = NdigW'(d + 1);
		end
		len_n = TEXT_LEN_W'(ndig) + TEXT_LEN_W'(neg_q);
		ovf_n = bovf_q || ({1'b0, len_n} > blen_q) || (len_n > MaxLen);
	end

	// Next character
	always_comb begin
		cur_digit = bcd_q[ptr_q*DIGIT_W +: DIGIT_W];
		item_n    = '0;
		if (ovf_q) begin
			item_n.char_code = ASCII_NUL;
			item_n.is_last   = 1'b1;
			item_n.status    = STATUS_OVERFLOW;
		end else begin
			item_n.char_code = sign_q ? ASCII_MINUS : (ASCII_ZERO | CHAR_W'(cur_digit));
			item_n.is_last   = !sign_q && (ptr_q == '0);
			item_n.status    = STATUS_OK;
			item_n.text_length = item_n.is_last ? len_q : '0;
		end
	end

	assign stat.conv_done = (cnt_q == STEP_CNT_W'(1));
	assign stat.slot_free = !out_valid_q || dout.ready;
	assign stat.last_char = item_n.is_last;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			shreg_q <= shreg_n;
			cnt_q   <= in_item.is_wide ? WIDE_STEPS : NARROW_STEPS;
			neg_q   <= neg_n;
			blen_q  <= in_item.buffer_len;
			bcd_q   <= '0;
			bovf_q  <= 1'b0;
		end else if (cmd.step) begin
			shreg_q <= {shreg_q[VALUE_W-BITS_PER_CYC-1:0], BITS_PER_CYC'(0)};
			cnt_q   <= cnt_q - STEP_CNT_W'(1);
			bcd_q   <= bcd_n;
			bovf_q  <= bovf_n;
		end
		if (cmd.check) begin
			len_q  <= len_n;
			ovf_q  <= ovf_n;
			ptr_q  <= PtrW'(ndig - NdigW'(1));
			sign_q <= neg_q;
		end else if (cmd.push) begin
			if (sign_q) begin
				sign_q <= 1'b0;
			end else begin
				ptr_q <= ptr_q - PtrW'(1);
			end
		end
		if (cmd.push) out_q <= item_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign dout.valid = out_valid_q;
	assign dout.data  = out_q;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import b2d_pkg::*;

	localparam int TEXT_MAX     = MAX_CHARS_DEF;
	localparam int RANDOM_ITEMS = 106;
	// Receiver back-pressure burst, long enough to fill the unit and stall its input
	localparam int HOLD_CYCLES  = 300;
	// Cycles with no transaction on either side before the run is declared hung
	localparam int STALL_LIMIT  = 2000;
	// Settling time after the last character: a wide conversion plus its full text
	localparam int DRAIN_CYCLES = 40;
	localparam int BUSY_PCT     = 35;

	// How a stimulus row is checked: by the predictor, against typed text,
	// or as a single overflow transaction
	typedef enum logic [1:0] {
		CHK_PREDICT,
		CHK_TEXT,
		CHK_OVERFLOW
	} check_kind_t;

	logic clk = 1'b0;
	logic arst_n;

	b2d_in_if  din_if ();
	b2d_out_if dout_if ();

	binary_to_decimal_ascii_unit #(
		.MAX_CHARS(TEXT_MAX)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.din   (din_if),
		.dout  (dout_if)
	);

	always #5 clk = ~clk;

	// Characters still owed by the unit, oldest first
	out_item_t pending_chars[$];

	// Directed table, one entry per row in each queue
	in_item_t    row_items[$];
	check_kind_t row_kinds[$];
	string       row_texts[$];

	int fails        = 0;
	int stall_cycles = 0;
	int tx_idle_pct  = BUSY_PCT;
	int rx_idle_pct  = BUSY_PCT;
	bit hold_req     = 1'b0;

	function automatic void expect_char(logic [CHAR_W-1:0] ch, int pos, int len);
		out_item_t c;
		c.char_code   = ch;
		c.is_last     = (pos == len - 1);
		c.status      = STATUS_OK;
		c.text_length = c.is_last ? TEXT_LEN_W'(len) : '0;
		pending_chars.push_back(c);
	endfunction

	function automatic void expect_overflow();
		out_item_t c;
		c.char_code   = ASCII_NUL;
		c.is_last     = 1'b1;
		c.status      = STATUS_OVERFLOW;
		c.text_length = '0;
		pending_chars.push_back(c);
	endfunction

	// Work out the decimal text of one operand and queue its characters
	function automatic void predict_decimal(in_item_t it);
		logic [VALUE_W-1:0] mag;
		logic [31:0]        low_mag;
		logic               neg;
		logic [CHAR_W-1:0]  text[$];
		int                 len;
		if (it.is_wide) begin
			neg = it.is_signed & it.value[VALUE_W-1];
			mag = neg ? -it.value : it.value;
		end else begin
			// Upper half is ignored; negate within 32 bits so the most negative
			// narrow value keeps its magnitude
			neg     = it.is_signed & it.value[31];
			low_mag = neg ? -it.value[31:0] : it.value[31:0];
			mag     = {32'b0, low_mag};
		end
		// Zero still yields one digit
		do begin
			text.push_front(ASCII_ZERO + CHAR_W'(mag % 10));
			mag = mag / 10;
		end while (mag != 0);
		if (neg)
			text.push_front(ASCII_MINUS);
		len = text.size();
		if (len > int'(it.buffer_len) || len > TEXT_MAX) begin
			expect_overflow();
		end else begin
			foreach (text[i])
				expect_char(text[i], i, len);
		end
	endfunction

	task automatic add_row(logic [VALUE_W-1:0] value, logic sgn, logic wide, int blen,
			check_kind_t kind, string text);
		in_item_t it;
		it.value      = value;
		it.is_signed  = sgn;
		it.is_wide    = wide;
		it.buffer_len = BUF_LEN_W'(blen);
		row_items.push_back(it);
		row_kinds.push_back(kind);
		row_texts.push_back(text);
	endtask

	// Offer one operand, idling first at random, and queue what it owes once
	// the transaction is taken. Valid is left high so the next call can keep it
	// up without a drop in the same step.
	task automatic send_item(in_item_t it, check_kind_t kind, string text);
		while ($urandom_range(99) < tx_idle_pct) begin
			din_if.valid <= 1'b0;
			@(posedge clk);
		end
		din_if.valid <= 1'b1;
		din_if.data  <= it;
		do @(posedge clk); while (!din_if.ready);
		case (kind)
			CHK_PREDICT: begin
				predict_decimal(it);
			end
			CHK_TEXT: begin
				for (int i = 0; i < text.len(); i++)
					expect_char(text[i], i, text.len());
			end
			default: begin
				expect_overflow();
			end
		endcase
	endtask

	// Receiver: random stalls, plus one long hold-off on request
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		dout_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				dout_if.ready <= 1'b0;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				dout_if.ready <= 1'b0;
			end else begin
				dout_if.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Check every character taken against the oldest one owed, and track how
	// long the interfaces have gone without a transaction
	always @(posedge clk) begin : char_monitor
		out_item_t want;
		if (arst_n) begin
			if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (dout_if.valid && dout_if.ready) begin
				if (pending_chars.size() == 0) begin
					$error("character with no conversion pending: char_code %h",
						dout_if.data.char_code);
					fails++;
				end else begin
					want = pending_chars.pop_front();
					if (dout_if.data.char_code !== want.char_code) begin
						$error("char_code: expected %h, got %h", want.char_code,
							dout_if.data.char_code);
						fails++;
					end
					if (dout_if.data.is_last !== want.is_last) begin
						$error("is_last: expected %b, got %b", want.is_last,
							dout_if.data.is_last);
						fails++;
					end
					if (dout_if.data.status !== want.status) begin
						$error("status: expected %b, got %b", want.status,
							dout_if.data.status);
						fails++;
					end
					if (dout_if.data.text_length !== want.text_length) begin
						$error("text_length: expected %0d, got %0d", want.text_length,
							dout_if.data.text_length);
						fails++;
					end
				end
			end
		end
	end

	// Hang detection: end the run once nothing has moved for too long
	initial begin : watchdog
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		in_item_t           it;
		logic [VALUE_W-1:0] raw;
		logic [VALUE_W-1:0] p10;
		int                 mode;

		arst_n       <= 1'b0;
		din_if.valid <= 1'b0;
		din_if.data  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Zero in both widths, and an empty buffer
		add_row(64'd0, 1'b0, 1'b0, 63, CHK_TEXT, "0");
		add_row(64'd0, 1'b1, 1'b1, 1, CHK_TEXT, "0");
		add_row(64'd0, 1'b0, 1'b1, 0, CHK_OVERFLOW, "");
		add_row(64'h5A5A_5A5A_0000_0000, 1'b1, 1'b0, 1, CHK_TEXT, "0");
		// Widest text: exactly at the limit, then one short
		add_row('1, 1'b0, 1'b1, 63, CHK_TEXT, "18446744073709551615");
		add_row('1, 1'b0, 1'b1, 20, CHK_TEXT, "18446744073709551615");
		add_row('1, 1'b0, 1'b1, 19, CHK_OVERFLOW, "");
		// Most negative and most positive wide values
		add_row(64'h8000_0000_0000_0000, 1'b1, 1'b1, 20, CHK_TEXT, "-9223372036854775808");
		add_row(64'h8000_0000_0000_0000, 1'b1, 1'b1, 19, CHK_OVERFLOW, "");
		add_row(64'h8000_0000_0000_0000, 1'b0, 1'b1, 63, CHK_TEXT, "9223372036854775808");
		add_row(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 63, CHK_TEXT, "9223372036854775807");
		add_row('1, 1'b1, 1'b1, 2, CHK_TEXT, "-1");
		add_row('1, 1'b1, 1'b1, 1, CHK_OVERFLOW, "");
		// Narrow extremes with junk in the upper half
		add_row(64'hA5A5_A5A5_FFFF_FFFF, 1'b0, 1'b0, 10, CHK_TEXT, "4294967295");
		add_row(64'h1234_5678_8000_0000, 1'b1, 1'b0, 11, CHK_TEXT, "-2147483648");
		add_row(64'hFFFF_FFFF_7FFF_FFFF, 1'b1, 1'b0, 63, CHK_TEXT, "2147483647");
		// Digit count boundaries
		add_row(64'd9, 1'b0, 1'b1, 1, CHK_TEXT, "9");
		add_row(64'd10, 1'b0, 1'b1, 1, CHK_OVERFLOW, "");
		add_row(64'd10, 1'b1, 1'b0, 2, CHK_TEXT, "10");
		add_row(64'h8AC7_2304_89E8_0000, 1'b0, 1'b1, 20, CHK_TEXT, "10000000000000000000");
		add_row(64'h0123_4567_89AB_CDEF, 1'b0, 1'b1, 63, CHK_PREDICT, "");
		add_row(64'hDEAD_BEEF_FFFF_FF85, 1'b1, 1'b0, 63, CHK_PREDICT, "");
		add_row(64'hFEDC_BA98_7654_3210, 1'b1, 1'b1, 42, CHK_PREDICT, "");
		add_row(64'd1_000_000_000, 1'b0, 1'b0, 10, CHK_PREDICT, "");

		foreach (row_items[i])
			send_item(row_items[i], row_kinds[i], row_texts[i]);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Stretch with no random idling on either side, then a long receiver hold-off while
			// the sender keeps offering
			if (n == 40) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			if (n == 70) begin
				tx_idle_pct = BUSY_PCT;
				rx_idle_pct = BUSY_PCT;
			end
			if (n == 90) begin
				tx_idle_pct = 0;
				hold_req = 1'b1;
			end
			if (n == 100)
				tx_idle_pct = BUSY_PCT;

			raw  = {$urandom, $urandom};
			mode = $urandom_range(9);
			case (mode)
				0, 1, 2: begin
					it.value = raw;
				end
				3, 4, 5: begin
					// Short positive magnitudes
					it.value = raw >> $urandom_range(63);
				end
				6, 7: begin
					// Short negative magnitudes
					it.value = -(raw >> $urandom_range(63));
				end
				8: begin
					// Around a power of ten, where the digit count changes
					p10 = 64'd1;
					repeat ($urandom_range(19)) p10 = p10 * 10;
					it.value = p10 + 64'($urandom_range(2)) - 64'd1;
				end
				default: begin
					case ($urandom_range(3))
						0: it.value = '0;
						1: it.value = '1;
						2: it.value = 64'h8000_0000_0000_0000;
						default: it.value = {raw[63:32], 32'h8000_0000};
					endcase
				end
			endcase
			it.is_signed  = 1'($urandom_range(1));
			it.is_wide    = 1'($urandom_range(1));
			// Mostly a buffer that fits; now and then any length, overflow included
			it.buffer_len = ($urandom_range(3) == 0) ? BUF_LEN_W'($urandom_range(63))
				: BUF_LEN_W'($urandom_range(20, 63));
			send_item(it, CHK_PREDICT, "");
		end

		// Drop valid in the step the last operand was taken
		din_if.valid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		// Allow stray characters time to surface
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
